// File: hdl/yvi_pkg.sv
// Package for the YUYV 4:2:2 to I420 converter: register indexes, reset values,
// the position flags passed from the counter to the datapath and the frame size clamp.
// No dependencies.
package yvi_pkg;

  localparam int CFG_DW = 12;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam logic [CFG_DW-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_DW-1:0] FRAME_HEIGHT_RST = 12'd480;

  // Position of the current request inside the frame
  typedef struct packed {
    logic odd_row;
    logic last_px;
  } pos_t;

  // Even size in [2, max], lowest register bit dropped
  function automatic logic [13:0] eff_size(logic [CFG_DW-1:0] r, logic [13:0] mx);
    logic [13:0] v;
    v = {2'b00, r & 12'hFFE};
    if (v < 14'd2) v = 14'd2;
    if (v > mx) v = mx & ~14'd1;
    if (v < 14'd2) v = 14'd2;
    return v;
  endfunction

endpackage

// File: hdl/yvi_in_if.sv
// Input channel of the converter: one YUYV macropixel per request.
// No dependencies.
interface yvi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_first;
  logic [7:0] chroma_blue;
  logic [7:0] luma_second;
  logic [7:0] chroma_red;
  logic       frame_start;

  modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                  frame_start, input ready);
  modport sink (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                frame_start, output ready);
endinterface

// File: hdl/yvi_out_if.sv
// Result channel of the converter: two luma bytes and optional averaged chroma.
// No dependencies.
interface yvi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_out_first;
  logic [7:0] luma_out_second;
  logic       chroma_valid;
  logic [7:0] cb_out;
  logic [7:0] cr_out;
  logic       end_of_frame;

  modport source (output valid, luma_out_first, luma_out_second, chroma_valid, cb_out,
                  cr_out, end_of_frame, input ready);
  modport sink (input valid, luma_out_first, luma_out_second, chroma_valid, cb_out,
                cr_out, end_of_frame, output ready);
endinterface

// File: hdl/yuyv_to_i420_converter_top.sv
// YUYV 4:2:2 to I420 converter, top level. Takes one macropixel per clock and
// returns each result through the stage 1 and output registers; the registered
// read of the chroma line store, which is written on even rows and read on odd
// rows at the pair column, arrives beside stage 1. Sustained rate is one request
// per cycle while the result side takes results. Line store entries are not
// cleared after reset: the first row after reset must be an even row. Depends on
// yvi_pkg, yvi_in_if, yvi_out_if, yvi_ram and yvi_ctr.
module yuyv_to_i420_converter_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  yvi_pkg::cfg_reg_t         cfg_index,
  input  logic [yvi_pkg::CFG_DW-1:0] cfg_data,
  yvi_in_if.sink                    in_if,
  yvi_out_if.source                 out_if
);

  localparam int DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
  localparam int CW    = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1;

  logic          accept, adv2;
  logic [CW-1:0] col;
  yvi_pkg::pos_t pos;
  logic [15:0]   store_rd;

  logic       s1_valid_r;
  logic [7:0] s1_y0_r, s1_y1_r, s1_u_r, s1_v_r;
  logic       s1_odd_r, s1_eof_r;

  logic       out_valid_r, out_cv_r, out_eof_r;
  logic [7:0] out_y0_r, out_y1_r, out_cb_r, out_cr_r;
  logic [8:0] cb_sum, cr_sum;

  assign adv2   = s1_valid_r && (!out_valid_r || out_if.ready);
  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = !s1_valid_r || adv2;

  yvi_ctr #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_ctr (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .step     (accept),
    .start    (in_if.frame_start),
    .col      (col),
    .pos      (pos)
  );

  // Read data tracks stage 1: it only changes when a new request enters
  yvi_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (accept && !pos.odd_row),
    .waddr(col),
    .wdata({in_if.chroma_red, in_if.chroma_blue}),
    .re   (accept && pos.odd_row),
    .raddr(col),
    .rdata(store_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (adv2) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_y0_r  <= in_if.luma_first;
      s1_y1_r  <= in_if.luma_second;
      s1_u_r   <= in_if.chroma_blue;
      s1_v_r   <= in_if.chroma_red;
      s1_odd_r <= pos.odd_row;
      s1_eof_r <= pos.last_px;
    end
  end

  assign cb_sum = {1'b0, store_rd[7:0]} + {1'b0, s1_u_r};
  assign cr_sum = {1'b0, store_rd[15:8]} + {1'b0, s1_v_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv2) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      out_y0_r  <= s1_y0_r;
      out_y1_r  <= s1_y1_r;
      out_cv_r  <= s1_odd_r;
      out_cb_r  <= s1_odd_r ? cb_sum[8:1] : 8'd0;
      out_cr_r  <= s1_odd_r ? cr_sum[8:1] : 8'd0;
      out_eof_r <= s1_eof_r;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.luma_out_first  = out_y0_r;
  assign out_if.luma_out_second = out_y1_r;
  assign out_if.chroma_valid    = out_cv_r;
  assign out_if.cb_out          = out_cb_r;
  assign out_if.cr_out          = out_cr_r;
  assign out_if.end_of_frame    = out_eof_r;

`ifndef SYNTHESIS
  // Hold a waiting result until it is taken
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |=>
      out_valid_r && $stable(out_y0_r) && $stable(out_eof_r))
    else $error("result changed while stalled");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted request lost in stage 1");

  a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv2 |=> s1_valid_r && $stable(s1_y0_r) && $stable(s1_odd_r))
    else $error("stage 1 changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> s1_valid_r && out_valid_r && !out_if.ready)
    else $error("input stalled without a full pipeline");
`endif

endmodule

// File: hdl/yvi_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module yvi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/yvi_ctr.sv
// Frame size registers and the pair column / row counters of the converter.
// Depends on yvi_pkg.
module yvi_ctr #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  localparam int CW = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1,
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  yvi_pkg::cfg_reg_t         cfg_index,
  input  logic [yvi_pkg::CFG_DW-1:0] cfg_data,
  input  logic                      step,
  input  logic                      start,
  output logic [CW-1:0]             col,
  output yvi_pkg::pos_t             pos
);

  localparam logic [13:0] WMAX = 14'(MAX_WIDTH);
  localparam logic [13:0] HMAX = 14'(MAX_HEIGHT);

  logic [yvi_pkg::CFG_DW-1:0] width_r, height_r;
  logic [CW-1:0] col_r, col_nxt, col_cur;
  logic [RW-1:0] row_r, row_nxt, row_cur;
  logic [CW:0]   pairs;
  logic [RW:0]   rows;
  logic          last_col, last_row;
  logic [13:0]   eff_w;

  always_comb begin
    eff_w = yvi_pkg::eff_size(width_r, WMAX);
    pairs = (CW+1)'(eff_w >> 1);
    rows  = (RW+1)'(yvi_pkg::eff_size(height_r, HMAX));
  end

  // Frame start restarts the counters before this request is handled
  assign col_cur = start ? '0 : col_r;
  assign row_cur = start ? '0 : row_r;

  assign last_col = ({1'b0, col_cur} + (CW+1)'(1)) >= pairs;
  assign last_row = ({1'b0, row_cur} + (RW+1)'(1)) >= rows;

  always_comb begin
    col_nxt = col_cur + CW'(1);
    row_nxt = row_cur;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_cur + RW'(1);
    end
  end

  assign col         = col_cur;
  assign pos.odd_row = row_cur[0];
  assign pos.last_px = last_col && last_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= yvi_pkg::FRAME_WIDTH_RST;
      height_r <= yvi_pkg::FRAME_HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          yvi_pkg::REG_FRAME_WIDTH:  width_r  <= cfg_data;
          yvi_pkg::REG_FRAME_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      if (step) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

endmodule
